// ----- rtl/core/gzhp_pkg.sv -----
// Package with the types and constants shared by the gzip/zlib header parser.
package gzhp_pkg;

    typedef enum logic [13:0] {
        PH_FIRST    = 14'b00000000000001,
        PH_GZ_ID2   = 14'b00000000000010,
        PH_GZ_CM    = 14'b00000000000100,
        PH_GZ_FLG   = 14'b00000000001000,
        PH_GZ_SKIP  = 14'b00000000010000,
        PH_GZ_XLO   = 14'b00000000100000,
        PH_GZ_XHI   = 14'b00000001000000,
        PH_GZ_XDATA = 14'b00000010000000,
        PH_GZ_NAME  = 14'b00000100000000,
        PH_GZ_COMM  = 14'b00001000000000,
        PH_GZ_HCRC  = 14'b00010000000000,
        PH_ZL_FLG   = 14'b00100000000000,
        PH_ZL_DICT  = 14'b01000000000000,
        PH_PAYLOAD  = 14'b10000000000000
    } t_phase;

    typedef enum logic [1:0] {
        FMT_UNKNOWN = 2'd0,
        FMT_RAW     = 2'd1,
        FMT_ZLIB    = 2'd2,
        FMT_GZIP    = 2'd3
    } t_format;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_DATA     = 2'd1,
        ERR_DISABLED = 2'd2,
        ERR_RSVD     = 2'd3
    } t_error;

    // Where the search for the next optional gzip section starts.
    typedef enum logic [1:0] {
        FROM_XLO  = 2'd0,
        FROM_NAME = 2'd1,
        FROM_COMM = 2'd2,
        FROM_HCRC = 2'd3
    } t_from;

    localparam logic [7:0] GZ_ID1    = 8'h1f;
    localparam logic [7:0] GZ_ID2    = 8'h8b;
    localparam logic [7:0] CM_DEFL   = 8'h08;
    localparam logic [3:0] NIB_ZLIB  = 4'h8;
    localparam logic [3:0] NIB_BAD6  = 4'h6;
    localparam logic [3:0] NIB_BAD7  = 4'h7;
    localparam logic [15:0] GZ_FIXED = 16'd6;
    localparam logic [15:0] GZ_HCRCN = 16'd2;
    localparam logic [15:0] ZL_DICTN = 16'd4;

    // Flag bit positions: bit0 FHCRC, bit1 FEXTRA, bit2 FNAME, bit3 FCOMMENT.
    localparam int GF_HCRC  = 0;
    localparam int GF_EXTRA = 1;
    localparam int GF_NAME  = 2;
    localparam int GF_COMM  = 3;

    typedef struct packed {
        t_phase      phase;
        t_format     fmt;
        logic [3:0]  gz_flags;
        logic [15:0] skip;
        logic [7:0]  xlen_lo;
        logic [31:0] dict_id;
        logic        fdict;
        t_error      err;
    } t_state;

    localparam int OUT_W = 48;

endpackage

// ----- rtl/core/gzhp_step.sv -----
// Next-state and result logic for one stream word of the header parser.
module gzhp_step (
    input  gzhp_pkg::t_state i_state,
    input  logic [7:0]       i_byte,
    input  logic             i_eoi,
    input  logic [2:0]       i_allowed,
    output gzhp_pkg::t_state o_state,
    output logic             o_emit
);

    function automatic gzhp_pkg::t_phase gz_next(input gzhp_pkg::t_from from_sel,
                                                 input logic [3:0] flags);
        gzhp_pkg::t_phase ph;
        if (from_sel == gzhp_pkg::FROM_XLO && flags[gzhp_pkg::GF_EXTRA])
            ph = gzhp_pkg::PH_GZ_XLO;
        else if (from_sel <= gzhp_pkg::FROM_NAME && flags[gzhp_pkg::GF_NAME])
            ph = gzhp_pkg::PH_GZ_NAME;
        else if (from_sel <= gzhp_pkg::FROM_COMM && flags[gzhp_pkg::GF_COMM])
            ph = gzhp_pkg::PH_GZ_COMM;
        else if (flags[gzhp_pkg::GF_HCRC])
            ph = gzhp_pkg::PH_GZ_HCRC;
        else
            ph = gzhp_pkg::PH_PAYLOAD;
        return ph;
    endfunction

    logic            cnt_done;
    logic [15:0]     cnt_next;
    logic [15:0]     xlen;
    gzhp_pkg::t_format first_fmt;
    gzhp_pkg::t_state  st;

    assign cnt_done = (i_state.skip <= 16'd1);
    assign cnt_next = cnt_done ? 16'd0 : i_state.skip - 16'd1;
    assign xlen     = {i_byte, i_state.xlen_lo};

    always_comb begin
        priority if (i_byte == gzhp_pkg::GZ_ID1) begin
            first_fmt = gzhp_pkg::FMT_GZIP;
        end else if (i_byte[3:0] == gzhp_pkg::NIB_ZLIB) begin
            first_fmt = gzhp_pkg::FMT_ZLIB;
        end else if (i_byte[3:0] == gzhp_pkg::NIB_BAD6 || i_byte[3:0] == gzhp_pkg::NIB_BAD7) begin
            first_fmt = gzhp_pkg::FMT_UNKNOWN;
        end else begin
            first_fmt = gzhp_pkg::FMT_RAW;
        end
    end

    always_comb begin
        st     = i_state;
        o_emit = 1'b0;
        if (i_state.err == gzhp_pkg::ERR_NONE) begin
            if (i_eoi) begin
                if (i_state.phase != gzhp_pkg::PH_PAYLOAD)
                    st.err = gzhp_pkg::ERR_DATA;
            end else begin
                unique case (i_state.phase)
                    gzhp_pkg::PH_FIRST: begin
                        if (first_fmt == gzhp_pkg::FMT_UNKNOWN) begin
                            st.err = gzhp_pkg::ERR_DATA;
                        end else if (!i_allowed[first_fmt - 2'd1]) begin
                            st.err = gzhp_pkg::ERR_DISABLED;
                        end else begin
                            st.fmt = first_fmt;
                            if (first_fmt == gzhp_pkg::FMT_GZIP) begin
                                st.phase = gzhp_pkg::PH_GZ_ID2;
                            end else if (first_fmt == gzhp_pkg::FMT_ZLIB) begin
                                if (i_byte[7])
                                    st.err = gzhp_pkg::ERR_DATA;
                                else
                                    st.phase = gzhp_pkg::PH_ZL_FLG;
                            end else begin
                                st.phase = gzhp_pkg::PH_PAYLOAD;
                                o_emit   = 1'b1;
                            end
                        end
                    end
                    gzhp_pkg::PH_GZ_ID2: begin
                        if (i_byte != gzhp_pkg::GZ_ID2) st.err = gzhp_pkg::ERR_DATA;
                        else st.phase = gzhp_pkg::PH_GZ_CM;
                    end
                    gzhp_pkg::PH_GZ_CM: begin
                        if (i_byte != gzhp_pkg::CM_DEFL) st.err = gzhp_pkg::ERR_DATA;
                        else st.phase = gzhp_pkg::PH_GZ_FLG;
                    end
                    gzhp_pkg::PH_GZ_FLG: begin
                        st.gz_flags = i_byte[4:1];
                        st.skip     = gzhp_pkg::GZ_FIXED;
                        st.phase    = gzhp_pkg::PH_GZ_SKIP;
                    end
                    gzhp_pkg::PH_GZ_SKIP: begin
                        st.skip = cnt_next;
                        if (cnt_done)
                            st.phase = gz_next(gzhp_pkg::FROM_XLO, i_state.gz_flags);
                    end
                    gzhp_pkg::PH_GZ_XLO: begin
                        st.xlen_lo = i_byte;
                        st.phase   = gzhp_pkg::PH_GZ_XHI;
                    end
                    gzhp_pkg::PH_GZ_XHI: begin
                        st.skip = xlen;
                        if (xlen == 16'd0)
                            st.phase = gz_next(gzhp_pkg::FROM_NAME, i_state.gz_flags);
                        else
                            st.phase = gzhp_pkg::PH_GZ_XDATA;
                    end
                    gzhp_pkg::PH_GZ_XDATA: begin
                        st.skip = cnt_next;
                        if (cnt_done)
                            st.phase = gz_next(gzhp_pkg::FROM_NAME, i_state.gz_flags);
                    end
                    gzhp_pkg::PH_GZ_NAME: begin
                        if (i_byte == 8'd0)
                            st.phase = gz_next(gzhp_pkg::FROM_COMM, i_state.gz_flags);
                    end
                    gzhp_pkg::PH_GZ_COMM: begin
                        if (i_byte == 8'd0)
                            st.phase = gz_next(gzhp_pkg::FROM_HCRC, i_state.gz_flags);
                    end
                    gzhp_pkg::PH_GZ_HCRC: begin
                        st.skip = cnt_next;
                        if (cnt_done) st.phase = gzhp_pkg::PH_PAYLOAD;
                    end
                    gzhp_pkg::PH_ZL_FLG: begin
                        if (i_byte[5]) begin
                            st.fdict = 1'b1;
                            st.skip  = gzhp_pkg::ZL_DICTN;
                            st.phase = gzhp_pkg::PH_ZL_DICT;
                        end else begin
                            st.phase = gzhp_pkg::PH_PAYLOAD;
                        end
                    end
                    gzhp_pkg::PH_ZL_DICT: begin
                        st.dict_id = {i_state.dict_id[23:0], i_byte};
                        st.skip    = cnt_next;
                        if (cnt_done) st.phase = gzhp_pkg::PH_PAYLOAD;
                    end
                    gzhp_pkg::PH_PAYLOAD: begin
                        o_emit = 1'b1;
                    end
                    default: begin
                        st = i_state;
                    end
                endcase
            end
        end
        // The checksum skip count is loaded whenever the header CRC section is entered.
        if (st.phase == gzhp_pkg::PH_GZ_HCRC && i_state.phase != gzhp_pkg::PH_GZ_HCRC)
            st.skip = gzhp_pkg::GZ_HCRCN;
        o_state = st;
    end

endmodule

// ----- rtl/core/gzip_zlib_header_parser_top.sv -----
// Top level of the gzip/zlib/raw deflate container header parser.
// Each input word carries one stream byte or an end-of-input mark and gives exactly one
// output word in the cycle after it is taken; while m_axis_tready is high it sustains
// one word per cycle, as its single output register is refilled in the same cycle it drains.
// The output word reports the detected format, the zlib dictionary id, the sticky error
// code and, once the header is consumed, the payload bytes with their valid flag.
module gzip_zlib_header_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
    input  logic        s_axis_tuser,  // [0] end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // [7:0] payload_byte, [8] header_done, [10:9] format,
                                       // [11] needs_dictionary, [43:12] dictionary_id,
                                       // [45:44] error_code, [47:46] zero
    output logic        m_axis_tuser   // [0] payload_valid
);

    gzhp_pkg::t_state r_state;
    gzhp_pkg::t_state n_state;
    logic [2:0]       r_allowed;
    logic             r_out_valid;
    logic [47:0]      r_out_data;
    logic             r_out_user;
    logic             step_emit;
    logic             in_fire;
    logic             hdr_done;
    logic [47:0]      n_out_data;

    gzhp_step u_step (
        .i_state   (r_state),
        .i_byte    (s_axis_tdata),
        .i_eoi     (s_axis_tuser),
        .i_allowed (r_allowed),
        .o_state   (n_state),
        .o_emit    (step_emit)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign hdr_done      = (n_state.err == gzhp_pkg::ERR_NONE) &&
                           (n_state.phase == gzhp_pkg::PH_PAYLOAD);
    assign n_out_data    = {2'b00, n_state.err, n_state.dict_id, n_state.fdict,
                            n_state.fmt, hdr_done, step_emit ? s_axis_tdata : 8'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allowed <= 3'd7;
        end else if (i_cfg_we) begin
            r_allowed <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase    <= gzhp_pkg::PH_FIRST;
            r_state.fmt      <= gzhp_pkg::FMT_UNKNOWN;
            r_state.gz_flags <= 4'd0;
            r_state.skip     <= 16'd0;
            r_state.xlen_lo  <= 8'd0;
            r_state.dict_id  <= 32'd0;
            r_state.fdict    <= 1'b0;
            r_state.err      <= gzhp_pkg::ERR_NONE;
            r_out_valid      <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= n_out_data;
            r_out_user <= step_emit;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // A reported payload word always comes with a completed header and no error.
    a_payload_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[8] && m_axis_tdata[45:44] == 2'd0))
        else $error("payload word without a completed header");

    // Once an error is recorded it never changes.
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.err != gzhp_pkg::ERR_NONE) |=> (r_state.err == $past(r_state.err)))
        else $error("sticky error changed");

    // An accepted word always produces an output word in the next cycle.
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> m_axis_tvalid)
        else $error("accepted word produced no output");

    // The parser phase register stays one-hot.
    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state.phase))
        else $error("phase register lost one-hot encoding");

endmodule

// ----- tb/sv/gzip_header_checker.sv -----
// Checker for the gzip/zlib header parser: predicts each output word and compares it.
module gzip_header_checker
    import gzhp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_wdata,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,
    input  logic             s_axis_tuser,
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [OUT_W-1:0] m_axis_tdata,
    input  logic             m_axis_tuser,
    output int               fail_count,
    output int               pending_words,
    output int               checked_words,
    output int               payload_words
);

    localparam int         ZL_FDICT_BIT = 5;
    localparam logic [3:0] CINFO_MAX    = 4'd7;
    localparam int         PRINT_LIMIT  = 20;

    typedef struct packed {
        logic [1:0]  pad;
        t_error      err;
        logic [31:0] dict_id;
        logic        need_dict;
        t_format     fmt;
        logic        hdr_done;
        logic [7:0]  payload;
    } t_parse_word;

    typedef struct packed {
        logic        pv;
        t_parse_word word;
    } t_parse_result;

    t_parse_result expected_results[$];

    logic [2:0]  fmt_mask;
    t_phase      cur_phase;
    t_format     found_fmt;
    logic [3:0]  gz_opts;
    logic [15:0] bytes_left;
    logic [7:0]  xlen_low;
    logic [31:0] dict_word;
    logic        dict_flag;
    t_error      err_hold;

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) begin
            $display("Mismatch at result word %0d: %s is 0x%0h, expected 0x%0h.",
                     checked_words, field, got, want);
        end
    endtask

    task automatic take_one(output bit done);
        if (bytes_left <= 16'd1) begin
            bytes_left = '0;
            done = 1'b1;
        end else begin
            bytes_left = bytes_left - 16'd1;
            done = 1'b0;
        end
    endtask

    task automatic enter_gzip_section(input t_from from);
        if (from <= FROM_XLO && gz_opts[GF_EXTRA]) begin
            cur_phase = PH_GZ_XLO;
        end else if (from <= FROM_NAME && gz_opts[GF_NAME]) begin
            cur_phase = PH_GZ_NAME;
        end else if (from <= FROM_COMM && gz_opts[GF_COMM]) begin
            cur_phase = PH_GZ_COMM;
        end else if (gz_opts[GF_HCRC]) begin
            bytes_left = GZ_HCRCN;
            cur_phase = PH_GZ_HCRC;
        end else begin
            cur_phase = PH_PAYLOAD;
        end
    endtask

    task automatic advance_parser(input logic [7:0] b, input logic eoi,
                                  output t_parse_result res);
        logic    emit;
        t_format f;
        bit      done;
        emit = 1'b0;
        if (err_hold == ERR_NONE) begin
            if (eoi) begin
                if (cur_phase != PH_PAYLOAD) err_hold = ERR_DATA;
            end else begin
                case (cur_phase)
                    PH_FIRST: begin
                        if (b == GZ_ID1) f = FMT_GZIP;
                        else if (b[3:0] == NIB_ZLIB) f = FMT_ZLIB;
                        else if (b[3:0] == NIB_BAD6 || b[3:0] == NIB_BAD7) f = FMT_UNKNOWN;
                        else f = FMT_RAW;
                        if (f == FMT_UNKNOWN) begin
                            err_hold = ERR_DATA;
                        end else if (!fmt_mask[int'(f) - 1]) begin
                            err_hold = ERR_DISABLED;
                        end else begin
                            found_fmt = f;
                            if (f == FMT_GZIP) begin
                                cur_phase = PH_GZ_ID2;
                            end else if (f == FMT_ZLIB) begin
                                if (b[7:4] > CINFO_MAX) err_hold = ERR_DATA;
                                else cur_phase = PH_ZL_FLG;
                            end else begin
                                cur_phase = PH_PAYLOAD;
                                emit = 1'b1;
                            end
                        end
                    end
                    PH_GZ_ID2: begin
                        if (b != GZ_ID2) err_hold = ERR_DATA;
                        else cur_phase = PH_GZ_CM;
                    end
                    PH_GZ_CM: begin
                        if (b != CM_DEFL) err_hold = ERR_DATA;
                        else cur_phase = PH_GZ_FLG;
                    end
                    PH_GZ_FLG: begin
                        gz_opts = b[4:1];
                        bytes_left = GZ_FIXED;
                        cur_phase = PH_GZ_SKIP;
                    end
                    PH_GZ_SKIP: begin
                        take_one(done);
                        if (done) enter_gzip_section(FROM_XLO);
                    end
                    PH_GZ_XLO: begin
                        xlen_low = b;
                        cur_phase = PH_GZ_XHI;
                    end
                    PH_GZ_XHI: begin
                        bytes_left = {b, xlen_low};
                        if (bytes_left == '0) enter_gzip_section(FROM_NAME);
                        else cur_phase = PH_GZ_XDATA;
                    end
                    PH_GZ_XDATA: begin
                        take_one(done);
                        if (done) enter_gzip_section(FROM_NAME);
                    end
                    PH_GZ_NAME: begin
                        if (b == 8'h00) enter_gzip_section(FROM_COMM);
                    end
                    PH_GZ_COMM: begin
                        if (b == 8'h00) enter_gzip_section(FROM_HCRC);
                    end
                    PH_GZ_HCRC: begin
                        take_one(done);
                        if (done) cur_phase = PH_PAYLOAD;
                    end
                    PH_ZL_FLG: begin
                        if (b[ZL_FDICT_BIT]) begin
                            dict_flag = 1'b1;
                            bytes_left = ZL_DICTN;
                            cur_phase = PH_ZL_DICT;
                        end else begin
                            cur_phase = PH_PAYLOAD;
                        end
                    end
                    PH_ZL_DICT: begin
                        dict_word = {dict_word[23:0], b};
                        take_one(done);
                        if (done) cur_phase = PH_PAYLOAD;
                    end
                    PH_PAYLOAD: begin
                        emit = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
        res.pv             = emit;
        res.word.pad       = '0;
        res.word.err       = err_hold;
        res.word.dict_id   = dict_word;
        res.word.need_dict = dict_flag;
        res.word.fmt       = found_fmt;
        res.word.hdr_done  = (err_hold == ERR_NONE && cur_phase == PH_PAYLOAD);
        res.word.payload   = emit ? b : 8'h00;
    endtask

    always @(posedge i_clk) begin
        t_parse_result next_res;
        t_parse_result want;
        t_parse_word   got;
        if (!i_rst_n) begin
            fmt_mask      = 3'b111;
            cur_phase     = PH_FIRST;
            found_fmt     = FMT_UNKNOWN;
            gz_opts       = '0;
            bytes_left    = '0;
            xlen_low      = '0;
            dict_word     = '0;
            dict_flag     = 1'b0;
            err_hold      = ERR_NONE;
            fail_count    = 0;
            checked_words = 0;
            payload_words = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) fmt_mask = i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                advance_parser(s_axis_tdata, s_axis_tuser, next_res);
                expected_results.push_back(next_res);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_parse_word'(m_axis_tdata);
                if (expected_results.size() == 0) begin
                    report_mismatch("word with nothing expected", m_axis_tdata[31:0], '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser !== want.pv)
                        report_mismatch("payload_valid", 32'(m_axis_tuser), 32'(want.pv));
                    if (got.payload !== want.word.payload)
                        report_mismatch("payload_byte", 32'(got.payload),
                                        32'(want.word.payload));
                    if (got.hdr_done !== want.word.hdr_done)
                        report_mismatch("header_done", 32'(got.hdr_done),
                                        32'(want.word.hdr_done));
                    if (got.fmt !== want.word.fmt)
                        report_mismatch("format", 32'(got.fmt), 32'(want.word.fmt));
                    if (got.need_dict !== want.word.need_dict)
                        report_mismatch("needs_dictionary", 32'(got.need_dict),
                                        32'(want.word.need_dict));
                    if (got.dict_id !== want.word.dict_id)
                        report_mismatch("dictionary_id", got.dict_id, want.word.dict_id);
                    if (got.err !== want.word.err)
                        report_mismatch("error_code", 32'(got.err), 32'(want.word.err));
                    if (got.pad !== want.word.pad)
                        report_mismatch("padding bits", 32'(got.pad), 32'(want.word.pad));
                    if (want.pv) payload_words++;
                end
                checked_words++;
            end
        end
        pending_words = expected_results.size();
    end

endmodule

// ----- tb/sv/tb_gzip_zlib_header_parser_top.sv -----
// Testbench top for the gzip/zlib header parser: stimulus, flow control and verdict.
module tb_gzip_zlib_header_parser_top;
    import gzhp_pkg::*;

    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         HOLDOFF_CYCLES  = 200;
    localparam int         PAYLOAD_PHASES  = 5;
    localparam int         PHASE_WORDS     = 150;
    localparam int         FLG_HCRC        = 1;
    localparam int         FLG_EXTRA       = 2;
    localparam int         FLG_NAME        = 3;
    localparam int         FLG_COMM        = 4;
    localparam int         ZL_FDICT_BIT    = 5;
    localparam logic [7:0] GZ_ALL_SECTIONS = 8'h1e;

    typedef enum int {
        BAD_NIBBLE,
        FMT_OFF,
        BAD_CINFO,
        BAD_ID2,
        BAD_METHOD,
        CUT_SHORT
    } t_fault;

    typedef struct packed {
        logic       eoi;
        logic [7:0] data;
    } t_in_word;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [2:0]        i_cfg_wdata   = 3'b000;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata  = 8'h00;
    logic              s_axis_tuser  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tuser;

    int fail_count;
    int pending_words;
    int checked_words;
    int payload_words;

    t_in_word   stream_q[$];
    string      stream_kind;
    logic [2:0] start_mask;
    int         sent_words       = 0;
    int         mask_writes      = 0;
    int         holdoff_requests = 0;
    int         holdoff_served   = 0;
    int         holdoff_left     = 0;
    int         pattern_left     = 0;
    int         stall_pct        = 0;
    int         quiet_cycles     = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    gzip_zlib_header_parser_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    gzip_header_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending_words (pending_words),
        .checked_words (checked_words),
        .payload_words (payload_words)
    );

    // The receiver stalls on its own changing pattern, with long hold-offs on request.
    always @(negedge i_clk) begin
        if (holdoff_left > 0) begin
            holdoff_left--;
            m_axis_tready <= 1'b0;
        end else if (holdoff_served != holdoff_requests) begin
            holdoff_served++;
            holdoff_left = HOLDOFF_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(20, 80);
                case ($urandom_range(0, 4))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 25;
                    3: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end else begin
                pattern_left--;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no word moved for %0d cycles.", WATCHDOG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic add_word(input logic [7:0] data, input logic eoi = 1'b0);
        t_in_word w;
        w.eoi  = eoi;
        w.data = data;
        stream_q.push_back(w);
    endtask

    task automatic add_random_byte();
        add_word(8'($urandom_range(0, 255)));
    endtask

    task automatic add_text();
        repeat ($urandom_range(0, 6)) add_word(8'($urandom_range(1, 255)));
        add_word(8'h00);
    endtask

    task automatic add_gzip_header();
        logic [7:0] flg;
        int         xlen;
        flg = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 1) flg = flg | GZ_ALL_SECTIONS;
        add_word(GZ_ID1);
        add_word(GZ_ID2);
        add_word(CM_DEFL);
        add_word(flg);
        repeat (int'(GZ_FIXED)) add_random_byte();
        if (flg[FLG_EXTRA]) begin
            xlen = ($urandom_range(0, 7) == 0) ? $urandom_range(256, 400) : $urandom_range(0, 5);
            add_word(xlen[7:0]);
            add_word(xlen[15:8]);
            repeat (xlen) add_random_byte();
        end
        if (flg[FLG_NAME]) add_text();
        if (flg[FLG_COMM]) add_text();
        if (flg[FLG_HCRC]) repeat (int'(GZ_HCRCN)) add_random_byte();
    endtask

    task automatic add_zlib_header();
        logic [7:0] flg;
        add_word({4'($urandom_range(0, 7)), NIB_ZLIB});
        flg = 8'($urandom_range(0, 255));
        flg[ZL_FDICT_BIT] = ($urandom_range(0, 4) < 3);
        add_word(flg);
        if (flg[ZL_FDICT_BIT]) repeat (int'(ZL_DICTN)) add_random_byte();
    endtask

    function automatic logic [7:0] raw_first_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == GZ_ID1 || b[3:0] == NIB_ZLIB || b[3:0] == NIB_BAD6
                   || b[3:0] == NIB_BAD7);
        return b;
    endfunction

    task automatic build_header();
        int       pick;
        int       cut;
        t_fault   fault;
        t_format  off_fmt;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        start_mask = 3'($urandom_range(0, 7));
        if (pick < 40) begin
            stream_kind = "gzip";
            start_mask[int'(FMT_GZIP) - 1] = 1'b1;
            add_gzip_header();
        end else if (pick < 65) begin
            stream_kind = "zlib";
            start_mask[int'(FMT_ZLIB) - 1] = 1'b1;
            add_zlib_header();
        end else if (pick < 75) begin
            stream_kind = "raw deflate";
            start_mask[int'(FMT_RAW) - 1] = 1'b1;
            add_word(raw_first_byte());
        end else begin
            fault = t_fault'($urandom_range(0, 5));
            case (fault)
                BAD_NIBBLE: begin
                    stream_kind = "reserved first nibble";
                    add_word({4'($urandom_range(0, 15)),
                              ($urandom_range(0, 1) == 1) ? NIB_BAD7 : NIB_BAD6});
                end
                FMT_OFF: begin
                    stream_kind = "disabled format";
                    off_fmt = t_format'($urandom_range(1, 3));
                    start_mask[int'(off_fmt) - 1] = 1'b0;
                    if (off_fmt == FMT_GZIP) add_gzip_header();
                    else if (off_fmt == FMT_ZLIB) add_zlib_header();
                    else add_word(raw_first_byte());
                end
                BAD_CINFO: begin
                    stream_kind = "zlib with bad window size";
                    start_mask[int'(FMT_ZLIB) - 1] = 1'b1;
                    add_word({4'($urandom_range(8, 15)), NIB_ZLIB});
                end
                BAD_ID2: begin
                    stream_kind = "gzip with bad second id byte";
                    start_mask[int'(FMT_GZIP) - 1] = 1'b1;
                    add_word(GZ_ID1);
                    do b = 8'($urandom_range(0, 255)); while (b == GZ_ID2);
                    add_word(b);
                end
                BAD_METHOD: begin
                    stream_kind = "gzip with bad method";
                    start_mask[int'(FMT_GZIP) - 1] = 1'b1;
                    add_word(GZ_ID1);
                    add_word(GZ_ID2);
                    do b = 8'($urandom_range(0, 255)); while (b == CM_DEFL);
                    add_word(b);
                end
                default: begin
                    stream_kind = "truncated header";
                    start_mask = 3'b111;
                    if ($urandom_range(0, 1) == 1) add_gzip_header();
                    else add_zlib_header();
                    cut = $urandom_range(0, stream_q.size() - 1);
                    while (stream_q.size() > cut) void'(stream_q.pop_back());
                    add_word(8'($urandom_range(0, 255)), 1'b1);
                end
            endcase
        end
    endtask

    task automatic write_format_mask(input logic [2:0] mask);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mask;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        mask_writes++;
    endtask

    task automatic send_stream();
        int burst_left;
        int gap;
        burst_left = 0;
        foreach (stream_q[i]) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0 && i > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            burst_left--;
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= stream_q[i].data;
            s_axis_tuser  <= stream_q[i].eoi;
            do @(posedge i_clk); while (!s_axis_tready);
            sent_words++;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_words != 0) @(negedge i_clk);
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        build_header();
        write_format_mask(start_mask);
        add_word(8'h00);
        add_word(8'hff);
        add_word(8'($urandom_range(0, 255)), 1'b1);
        add_word(8'h5a);
        add_word(8'ha5);
        send_stream();
        for (int ph = 0; ph < PAYLOAD_PHASES; ph++) begin
            wait_drained();
            if (ph == 0) write_format_mask(3'b000);
            else if (ph == 1) write_format_mask(3'b111);
            else write_format_mask(3'($urandom_range(0, 7)));
            stream_q.delete();
            repeat (PHASE_WORDS) add_word(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            if (ph == 1) holdoff_requests++;
            send_stream();
        end
        wait_drained();
        repeat (4) @(negedge i_clk);
        $display("Covered a %s stream: %0d words in, %0d results checked, %0d payload bytes.",
                 stream_kind, sent_words, checked_words, payload_words);
        $display("Format mask written %0d times, starting from %0b, with %0d long output stall(s).",
                 mask_writes, start_mask, holdoff_served);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/gzhp_pkg.sv
rtl/core/gzhp_step.sv
rtl/core/gzip_zlib_header_parser_top.sv
tb/sv/gzip_header_checker.sv
tb/sv/tb_gzip_zlib_header_parser_top.sv
